/* hw/rtl/bsled_pkg.sv */
// Shared types, constants and helpers for the button speed LED blinker.
// No dependencies; imported by button_speed_led_blinker.
`timescale 1ns / 1ps

package bsled_pkg;

  localparam int unsigned NumPresets       = 4;
  localparam int unsigned DebounceTicksDef = 3;

  localparam int unsigned PresetW = 12;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned TicksW  = 9;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [PresetW-1:0] PresetOff = 12'd3000;
  localparam logic [PresetW-1:0] PresetOn  = 12'd0;
  localparam int unsigned        MsPerTick = 10;
  // floor(x / 10) == (x * 6554) >> 16 for x below 16384
  localparam int unsigned        TickRecip = 6554;

  localparam logic [IdxW-1:0] IdxTop =
    (NumPresets < 4) ? IdxW'(NumPresets - 1) : IdxW'(3);

  localparam logic [PresetW-1:0] Preset0Rst = 12'd0;
  localparam logic [PresetW-1:0] Preset1Rst = 12'd250;
  localparam logic [PresetW-1:0] Preset2Rst = 12'd500;
  localparam logic [PresetW-1:0] Preset3Rst = 12'd3000;
  localparam logic [IdxW-1:0]    StartIdxRst = 2'd0;

  typedef enum logic [1:0] {
    PhIdle,
    PhConfirm,
    PhRelease
  } dbnc_phase_e;

  typedef enum logic [2:0] {
    RegPreset0,
    RegPreset1,
    RegPreset2,
    RegPreset3,
    RegStartIdx
  } reg_idx_e;

  // Ticks per blink phase: ceil(p / 10)
  function automatic logic [TicksW-1:0] half_ticks(input logic [PresetW-1:0] p);
    logic [25:0] prod;
    prod = (26'(p) + 26'(MsPerTick - 1)) * 26'(TickRecip);
    return prod[16 +: TicksW];
  endfunction

endpackage

/* hw/rtl/button_speed_led_blinker.sv */
// Button speed LED blinker: debounce, speed index and blink timing.
// Depends on bsled_pkg.
`timescale 1ns / 1ps

// Each input item is one 10 ms tick with the faster and slower button levels;
// each item yields one result item with the LED level and the speed index in
// use. The block takes one item per clock cycle while its result is not stalled:
// the item lands in an input register, the whole tick update (debounce, index
// step, blink counter) is combinational, and the result lands in an output
// register, and a stalled result holds the input register too. Presets and the
// start index sit behind an APB port at byte addresses 0x0, 0x4, 0x8, 0xC and
// 0x10; writing the start index also loads the speed index at once. Write
// registers only while no item is in flight.
module button_speed_led_blinker #(
  parameter int unsigned DEBOUNCE_TICKS = bsled_pkg::DebounceTicksDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        faster_btn_i,
  input  logic                        slower_btn_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        led_o,
  output logic [bsled_pkg::IdxW-1:0]  speed_index_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsled_pkg::AddrW-1:0] paddr,
  input  logic [bsled_pkg::DataW-1:0] pwdata,
  output logic [bsled_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import bsled_pkg::*;

  localparam int unsigned CntW = $clog2(DEBOUNCE_TICKS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(DEBOUNCE_TICKS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic                  in_valid_q, fb_q, sb_q;
  logic                  out_valid_q, led_out_q;
  logic [IdxW-1:0]       idx_out_q;
  logic                  advance;

  logic [PresetW-1:0]    preset_q [4];
  logic [IdxW-1:0]       start_idx_q;
  logic                  cfg_wr;
  reg_idx_e              cfg_sel;

  dbnc_phase_e           ph_q, ph_d;
  logic [CntW-1:0]       cnt_q, cnt_d, cnt_nx;
  logic                  pf_q, pf_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  bp_q, bp_d;
  logic [TicksW-1:0]     pt_q, pt_d;
  logic                  led_q, led_d;

  logic                  held, drop, idle_now, start, confirm_hit, blink_en, step_up;
  logic                  bp_cur;
  logic [TicksW-1:0]     pt_cur, pt_inc, need;
  logic [PresetW-1:0]    p_sel;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      fb_q <= faster_btn_i;
      sb_q <= slower_btn_i;
    end
    if (advance) begin
      led_out_q <= led_d;
      idx_out_q <= idx_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_o         = led_out_q;
  assign speed_index_o = idx_out_q;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    case (cfg_sel)
      RegPreset0:  prdata = DataW'(preset_q[0]);
      RegPreset1:  prdata = DataW'(preset_q[1]);
      RegPreset2:  prdata = DataW'(preset_q[2]);
      RegPreset3:  prdata = DataW'(preset_q[3]);
      RegStartIdx: prdata = DataW'(start_idx_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q[0] <= Preset0Rst;
      preset_q[1] <= Preset1Rst;
      preset_q[2] <= Preset2Rst;
      preset_q[3] <= Preset3Rst;
      start_idx_q <= StartIdxRst;
    end else if (cfg_wr) begin
      case (cfg_sel)
        RegPreset0:  preset_q[0] <= pwdata[PresetW-1:0];
        RegPreset1:  preset_q[1] <= pwdata[PresetW-1:0];
        RegPreset2:  preset_q[2] <= pwdata[PresetW-1:0];
        RegPreset3:  preset_q[3] <= pwdata[PresetW-1:0];
        RegStartIdx: start_idx_q <= pwdata[IdxW-1:0];
        default:     ;
      endcase
    end
  end

  // Tick decode
  assign held        = pf_q ? fb_q : sb_q;
  assign drop        = (ph_q != PhIdle) && !held;
  assign idle_now    = (ph_q == PhIdle) || drop;
  assign start       = idle_now && (fb_q || sb_q);
  assign blink_en    = idle_now && !(fb_q || sb_q);
  assign cnt_nx      = (cnt_q < CntMax) ? cnt_q + CntOne : cnt_q;
  assign confirm_hit = start ? (CntOne >= CntMax)
                             : ((ph_q == PhConfirm) && held && (cnt_nx >= CntMax));

  // Next debounce phase
  always_comb begin
    case (ph_q)
      PhIdle: begin
        if (start) begin
          ph_d = confirm_hit ? PhRelease : PhConfirm;
        end else begin
          ph_d = PhIdle;
        end
      end
      PhConfirm, PhRelease: begin
        if (start) begin
          ph_d = confirm_hit ? PhRelease : PhConfirm;
        end else if (drop) begin
          ph_d = PhIdle;
        end else if (confirm_hit) begin
          ph_d = PhRelease;
        end else begin
          ph_d = ph_q;
        end
      end
      default: ph_d = PhIdle;
    endcase
  end

  // Counters, index and blink
  assign p_sel   = preset_q[idx_q];
  assign need    = half_ticks(p_sel);
  assign bp_cur  = drop ? 1'b1 : bp_q;
  assign pt_cur  = drop ? '0 : pt_q;
  assign pt_inc  = pt_cur + TicksW'(1);
  assign step_up = start ? fb_q : pf_q;

  always_comb begin
    cnt_d = cnt_q;
    pf_d  = pf_q;
    idx_d = idx_q;
    bp_d  = bp_cur;
    pt_d  = pt_cur;
    led_d = led_q;
    if (start) begin
      cnt_d = CntOne;
      pf_d  = fb_q;
      bp_d  = 1'b1;
      pt_d  = '0;
    end else if (drop) begin
      cnt_d = '0;
    end else if (ph_q == PhConfirm) begin
      cnt_d = cnt_nx;
    end
    if (confirm_hit) begin
      if (step_up) begin
        if (idx_q < IdxTop) idx_d = idx_q + IdxW'(1);
      end else begin
        if (idx_q != '0) idx_d = idx_q - IdxW'(1);
      end
    end
    if (blink_en) begin
      if (p_sel == PresetOff) begin
        led_d = 1'b0;
        bp_d  = 1'b1;
        pt_d  = '0;
      end else if (p_sel == PresetOn) begin
        led_d = 1'b1;
        bp_d  = 1'b1;
        pt_d  = '0;
      end else begin
        led_d = bp_cur;
        if (pt_inc >= need) begin
          pt_d = '0;
          bp_d = !bp_cur;
        end else begin
          pt_d = pt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhIdle;
      cnt_q <= '0;
      pf_q  <= 1'b0;
      idx_q <= (StartIdxRst > IdxTop) ? IdxTop : StartIdxRst;
      bp_q  <= 1'b1;
      pt_q  <= '0;
      led_q <= 1'b0;
    end else if (cfg_wr && (cfg_sel == RegStartIdx)) begin
      idx_q <= (pwdata[IdxW-1:0] > IdxTop) ? IdxTop : pwdata[IdxW-1:0];
    end else if (advance) begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      pf_q  <= pf_d;
      idx_q <= idx_d;
      bp_q  <= bp_d;
      pt_q  <= pt_d;
      led_q <= led_d;
    end
  end

  a_stall_holds_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item left no result");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxTop)
    else $error("speed index beyond top preset");

  a_confirm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PhConfirm) |-> (cnt_q < CntMax))
    else $error("debounce count reached limit without confirm");

  a_blink_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PhIdle) |-> (bp_q && (pt_q == '0)))
    else $error("blink phase running during debounce");

endmodule
